@@ design/urta_pkg.sv @@
// ----------------------------------------------------------------------------
// urta_pkg
// Shared types, constants and the digit encoder for the radix-to-ASCII block.
// ----------------------------------------------------------------------------
package urta_pkg;

   localparam int VALUE_MAX_BITS      = 64;
   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int RADIX_BITS          = 6;
   localparam int CHAR_BITS           = 7;
   localparam int COUNT_BITS          = 7;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
   localparam logic [RADIX_BITS-1:0] DECIMAL_LIMIT = 6'd10;
   localparam logic [CHAR_BITS-1:0]  ASCII_ZERO    = 7'd48;
   localparam logic [CHAR_BITS-1:0]  ASCII_UPPER_A = 7'd65;

   typedef struct packed {
      logic [VALUE_MAX_BITS-1:0] value;
      logic [RADIX_BITS-1:0]     radix;
      logic                      bad;
   } job_type;

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] d);
      logic [CHAR_BITS-1:0] d_ext;
      d_ext = CHAR_BITS'(d);
      if (d < DECIMAL_LIMIT) begin
         return ASCII_ZERO + d_ext;
      end
      return ASCII_UPPER_A + d_ext - CHAR_BITS'(DECIMAL_LIMIT);
   endfunction

endpackage

@@ design/unsigned_radix_to_ascii.sv @@
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii
// Converts an unsigned number to ASCII digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
// Request channel (req_*): one transfer carries a value and a radix.
// Response channel (rsp_*): one transfer per digit, most significant first,
// rsp_tlast on the final digit; every transfer carries the digit count.
// A radix outside 2..36 gives one transfer with rsp_tuser set, char 0,
// count 0 and rsp_tlast set.
// Each digit is formed by the bit-serial divider (ST_DIVIDE) and then stored
// (ST_STORE); readout from the digit RAM passes through ST_FETCH and ST_SHOW
// for each digit. The divider is the limit on rate.
// A two-entry queue lets requests be taken while the converter works or the
// receiver stalls; a stalled response simply holds until rsp_tready.
// Reset clears the queue and the converter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module unsigned_radix_to_ascii
   import urta_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // value[63:0], radix[69:64], zero[71:70]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // digit_char[6:0], digit_count[13:7], zero[15:14]
   output logic        rsp_tlast,
   output logic        rsp_tuser    // bad_radix
);

   logic    f_valid, f_ready;
   job_type f_job;
   logic    q_valid, q_ready;
   job_type q_job;

   logic [CHAR_BITS-1:0]  digit_char;
   logic [COUNT_BITS-1:0] digit_count;

   urta_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_value  (req_tdata[VALUE_MAX_BITS-1:0]),
      .in_radix  (req_tdata[VALUE_MAX_BITS +: RADIX_BITS]),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job       (f_job)
   );

   urta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_job   (f_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_job    (q_job)
   );

   urta_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job       (q_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (digit_char),
      .out_last  (rsp_tlast),
      .out_count (digit_count),
      .out_bad   (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, digit_count, digit_char};

endmodule

@@ design/urta_front.sv @@
// ----------------------------------------------------------------------------
// urta_front
// Input stage: takes a request transfer, masks the value, flags a bad radix.
// ----------------------------------------------------------------------------
module urta_front
   import urta_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [VALUE_MAX_BITS-1:0]      in_value,
   input  logic [RADIX_BITS-1:0]          in_radix,
   output logic                           job_valid,
   input  logic                           job_ready,
   output job_type                        job
);

   localparam logic [VALUE_MAX_BITS-1:0] VALUE_MASK =
      {VALUE_MAX_BITS{1'b1}} >> (VALUE_MAX_BITS - VALUE_WIDTH);

   logic    hold_valid_ff, hold_valid_in;
   job_type hold_ff, hold_in;

   assign in_ready  = !hold_valid_ff || job_ready;
   assign job_valid = hold_valid_ff;
   assign job       = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (job_ready) begin
         hold_valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         hold_valid_in = 1'b1;
         hold_in.value = in_value & VALUE_MASK;
         hold_in.radix = in_radix;
         hold_in.bad   = !(in_radix inside {[RADIX_MIN:RADIX_MAX]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

@@ design/urta_queue.sv @@
// ----------------------------------------------------------------------------
// urta_queue
// Short job queue between the input stage and the converter.
// ----------------------------------------------------------------------------
module urta_queue
   import urta_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   job_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ design/urta_back.sv @@
// ----------------------------------------------------------------------------
// urta_back
// Converter: repeated bit-serial division by the radix, digit store, and
// most-significant-first readout.
// ----------------------------------------------------------------------------
module urta_back
   import urta_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  job_type               job,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [CHAR_BITS-1:0]  out_char,
   output logic                  out_last,
   output logic [COUNT_BITS-1:0] out_count,
   output logic                  out_bad
);

   localparam int AW = $clog2(VALUE_WIDTH);
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STORE,
      ST_FETCH,
      ST_SHOW
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RADIX_BITS-1:0]  rem_ff, rem_in;
   logic [RADIX_BITS-1:0]  radix_ff, radix_in;
   logic [AW-1:0]          bit_ff, bit_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   err_ff, err_in;

   logic [CHAR_BITS-1:0]   digit_mem [VALUE_WIDTH];
   logic [CHAR_BITS-1:0]   rd_data_ff;
   logic                   wr_en;

   logic [RADIX_BITS:0]    trial;
   logic [RADIX_BITS:0]    trial_diff;
   logic                   trial_ge;

   assign trial      = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign trial_ge   = (trial >= {1'b0, radix_ff});
   assign trial_diff = trial - {1'b0, radix_ff};
   assign wr_en      = (state_ff == ST_STORE);

   assign job_ready = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_SHOW);
   assign out_char  = err_ff ? '0 : rd_data_ff;
   assign out_last  = err_ff || (rd_idx_ff == '0);
   assign out_count = COUNT_BITS'(count_ff);
   assign out_bad   = err_ff;

   always_comb begin
      state_in  = state_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      radix_in  = radix_ff;
      bit_in    = bit_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      err_in    = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               count_in  = '0;
               rd_idx_in = '0;
               err_in    = job.bad;
               quo_in    = job.value[VALUE_WIDTH-1:0];
               radix_in  = job.radix;
               rem_in    = '0;
               bit_in    = '0;
               state_in  = job.bad ? ST_SHOW : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = trial_ge ? trial_diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], trial_ge};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == AW'(VALUE_WIDTH - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            count_in = count_ff + 1'b1;
            rem_in   = '0;
            bit_in   = '0;
            if (quo_ff == '0) begin
               rd_idx_in = count_ff[AW-1:0];
               state_in  = ST_FETCH;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_FETCH: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (out_ready) begin
               if (out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - 1'b1;
                  state_in  = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      radix_ff  <= radix_in;
      bit_ff    <= bit_in;
      rd_idx_ff <= rd_idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[count_ff[AW-1:0]] <= digit_to_ascii(rem_ff);
      end
      rd_data_ff <= digit_mem[rd_idx_ff];
   end

`ifndef SYNTHESIS
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_bad |-> out_last && (out_count == '0))
      else $error("bad radix result must be a single empty transfer");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_bad |-> (out_count != '0))
      else $error("digit transfer with zero count");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < radix_ff))
      else $error("partial remainder not below radix");

   a_first_digit_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) && (quo_ff == '0)
      |=> (CW'(rd_idx_ff) == count_ff - 1'b1))
      else $error("readout does not start at most significant digit");
`endif

endmodule
